[rtl/core/dllm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dllm_pkg
// shared types for the doubly linked list manager: operation codes,
// internal operation kinds and sequencer states
// ----------------------------------------------------------------------------
package dllm_pkg;

    // operation codes as they arrive on the input port
    typedef enum logic [1:0] {
        OP_HEAD   = 2'd0,
        OP_TAIL   = 2'd1,
        OP_AFTER  = 2'd2,
        OP_REMOVE = 2'd3
    } t_op;

    // operation as resolved at acceptance
    typedef enum logic [2:0] {
        K_NOP,
        K_HEAD,
        K_TAIL,
        K_AFTER,
        K_REMOVE
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WR1,
        S_WR2
    } t_state;

endpackage

`default_nettype wire

[rtl/core/dllm_link_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dllm_link_mem
// one link table: synchronous single write port, one read port with a
// registered output that updates only when a read is enabled
// ----------------------------------------------------------------------------
module dllm_link_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 7
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/doubly_linked_list_manager.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// doubly_linked_list_manager
// doubly linked list over a pool of NODES slots; previous and next links sit
// in two link tables, head, tail and count in registers
//
//   channel   direction  handshake                    payload
//   in        input      i_in_valid / o_in_stall      op, node_index, anchor_index
//   out       output     o_out_valid / i_out_stall    head, tail, count, empty, slot
//
// each transaction is one link table read, then two write states, S_WR1 and S_WR2,
// with at most one entry written per link table in each
// reset is synchronous; the list comes up empty, link tables are not cleared
// a stalled result holds the last write cycle of the following transaction
// a new transaction is taken while a result waits on the output
// ----------------------------------------------------------------------------
module doubly_linked_list_manager #(
    parameter int NODES = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [1:0]                 i_op,
    input  wire logic [$clog2(NODES)-1:0]   i_node_index,
    input  wire logic [$clog2(NODES)-1:0]   i_anchor_index,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [$clog2(NODES+1)-1:0]      o_head_slot,
    output logic [$clog2(NODES+1)-1:0]      o_tail_slot,
    output logic [$clog2(NODES+1)-1:0]      o_entry_count,
    output logic                            o_list_empty,
    output logic [$clog2(NODES)-1:0]        o_affected_slot
);

    import dllm_pkg::*;

    localparam int IW = $clog2(NODES);
    localparam int SW = $clog2(NODES + 1);
    localparam logic [SW-1:0] NONE_SLOT = SW'(NODES);

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;

    logic [IW-1:0] r_node, r_anchor, r_out_node;
    logic [SW-1:0] r_head, n_head, r_tail, n_tail, r_cnt, n_cnt;
    logic          r_out_valid;

    logic          in_take, wr2_go, out_free, list_empty;
    logic [SW-1:0] node_ext, anchor_ext, rd_next, rd_prev;

    logic          next_we, prev_we;
    logic [IW-1:0] next_waddr, prev_waddr, rd_addr;
    logic [SW-1:0] next_wdata, prev_wdata;

    assign list_empty = (r_cnt == '0);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign node_ext   = SW'(r_node);
    assign anchor_ext = SW'(r_anchor);

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_WR1;
            S_WR1:   n_state = S_WR2;
            S_WR2:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall = 1'b1;
        in_take    = 1'b0;
        wr2_go     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                in_take    = i_in_valid;
            end
            S_WR2:   wr2_go = out_free;
            default: ;
        endcase
    end

    // resolve the operation at acceptance against the current list state
    always_comb begin
        case (t_op'(i_op))
            OP_HEAD:  n_kind = K_HEAD;
            OP_TAIL:  n_kind = K_TAIL;
            OP_AFTER: begin
                if (list_empty) begin
                    n_kind = K_HEAD;
                end else if (SW'(i_anchor_index) < NONE_SLOT) begin
                    n_kind = K_AFTER;
                end else begin
                    n_kind = K_NOP;
                end
            end
            default:  n_kind = K_REMOVE;
        endcase
        if (SW'(i_node_index) >= NONE_SLOT) begin
            n_kind = K_NOP;
        end
    end

    // insert-after reads the anchor's links, everything else the node's own
    assign rd_addr = (t_op'(i_op) == OP_AFTER) ? i_anchor_index : i_node_index;

    // link table writes
    always_comb begin
        next_we    = 1'b0;
        next_waddr = r_node;
        next_wdata = NONE_SLOT;
        prev_we    = 1'b0;
        prev_waddr = r_node;
        prev_wdata = NONE_SLOT;
        if (r_state == S_WR1) begin
            case (r_kind)
                K_HEAD: begin
                    next_we    = 1'b1;
                    next_wdata = r_head;
                    prev_we    = 1'b1;
                end
                K_TAIL: begin
                    next_we    = 1'b1;
                    prev_we    = 1'b1;
                    prev_wdata = r_tail;
                end
                K_AFTER: begin
                    next_we    = 1'b1;
                    next_wdata = rd_next;
                    prev_we    = 1'b1;
                    prev_wdata = anchor_ext;
                end
                K_REMOVE: begin
                    // unlink from the neighbours
                    next_we    = (rd_prev < NONE_SLOT);
                    next_waddr = rd_prev[IW-1:0];
                    next_wdata = rd_next;
                    prev_we    = (rd_next < NONE_SLOT);
                    prev_waddr = rd_next[IW-1:0];
                    prev_wdata = rd_prev;
                end
                default: ;
            endcase
        end else if (wr2_go) begin
            case (r_kind)
                K_HEAD: begin
                    prev_we    = !list_empty && (r_head < NONE_SLOT);
                    prev_waddr = r_head[IW-1:0];
                    prev_wdata = node_ext;
                end
                K_TAIL: begin
                    next_we    = !list_empty && (r_tail < NONE_SLOT);
                    next_waddr = r_tail[IW-1:0];
                    next_wdata = node_ext;
                end
                K_AFTER: begin
                    prev_we    = (rd_next < NONE_SLOT);
                    prev_waddr = rd_next[IW-1:0];
                    prev_wdata = node_ext;
                    next_we    = 1'b1;
                    next_waddr = r_anchor;
                    next_wdata = node_ext;
                end
                K_REMOVE: begin
                    // the removed node's own links go last
                    next_we = 1'b1;
                    prev_we = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // head, tail and count after the operation
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_cnt  = r_cnt;
        if (wr2_go) begin
            case (r_kind)
                K_HEAD: begin
                    n_head = node_ext;
                    if (list_empty) n_tail = node_ext;
                    if (r_cnt < NONE_SLOT) n_cnt = r_cnt + 1'b1;
                end
                K_TAIL: begin
                    n_tail = node_ext;
                    if (list_empty) n_head = node_ext;
                    if (r_cnt < NONE_SLOT) n_cnt = r_cnt + 1'b1;
                end
                K_AFTER: begin
                    if (r_tail == anchor_ext) n_tail = node_ext;
                    if (r_cnt < NONE_SLOT) n_cnt = r_cnt + 1'b1;
                end
                K_REMOVE: begin
                    if (node_ext == r_head) n_head = rd_next;
                    if (node_ext == r_tail) n_tail = rd_prev;
                    if (!list_empty) n_cnt = r_cnt - 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= NONE_SLOT;
            r_tail      <= NONE_SLOT;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cnt   <= n_cnt;
            if (wr2_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind   <= n_kind;
            r_node   <= i_node_index;
            r_anchor <= i_anchor_index;
        end
        if (wr2_go) begin
            r_out_node <= r_node;
        end
    end

    dllm_link_mem #(
        .DEPTH (NODES),
        .WIDTH (SW)
    ) u_next_mem (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_re    (in_take),
        .i_raddr (rd_addr),
        .o_rdata (rd_next)
    );

    dllm_link_mem #(
        .DEPTH (NODES),
        .WIDTH (SW)
    ) u_prev_mem (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_re    (in_take),
        .i_raddr (rd_addr),
        .o_rdata (rd_prev)
    );

    // list state only moves in the final write cycle, so it doubles as the result
    assign o_out_valid     = r_out_valid;
    assign o_head_slot     = r_head;
    assign o_tail_slot     = r_tail;
    assign o_entry_count   = r_cnt;
    assign o_list_empty    = list_empty;
    assign o_affected_slot = r_out_node;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NONE_SLOT)
        else $error("node count beyond pool size");

    a_three_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |-> ##2 (r_state == S_WR2))
        else $error("transaction did not reach final write cycle");

    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> ($stable(r_cnt) && $stable(r_head)
                                          && $stable(r_tail)))
        else $error("list state moved under a waiting result");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!next_we && !prev_we))
        else $error("link table written while idle");

endmodule

`default_nettype wire
